// ===== rtl/core/mss_pkg.sv =====
`default_nettype none

package mss_pkg;

	localparam int DEF_MAX_ITEMS  = 256;
	localparam int DEF_VALUE_BITS = 31;

	localparam int IN_DATA_W  = 32;
	localparam int DIFF_W     = 39;
	localparam int OUT_DATA_W = 40;
	localparam int STATUS_W   = 2;

	localparam logic [DIFF_W-1:0] DIFF_MAX = '1;

	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_SHORT    = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_FETCH,
		ST_PIVOT,
		ST_SCAN,
		ST_ACC,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic issue;
	} scan_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/median_split_sum_difference.sv =====
// Loads a set of values, one word per cycle, with the final word marked by tlast, and returns
// one result word: the sum of the larger n - n/2 values minus the sum of the n/2 smallest.
// Each stored value is ranked against the whole set by one comparator that sweeps the single
// read port of the value memory, where n is the number of stored values; the input is not
// ready during the selection after the last word.
// A set of fewer than two values reports a short status with a zero difference at once.
// Values beyond MAX_ITEMS are dropped and the result carries the overflow status.
`default_nettype none

module median_split_sum_difference
	import mss_pkg::*;
#(
	parameter int MAX_ITEMS  = DEF_MAX_ITEMS,
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // value[30:0], zero pad [31]
	input  wire logic                  s_axis_tlast,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic      [OUT_DATA_W-1:0] m_axis_tdata,   // difference[38:0], zero pad [39]
	output logic      [STATUS_W-1:0]   m_axis_tuser    // status[1:0]
);

	localparam int AW    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CW    = $clog2(MAX_ITEMS + 1);
	localparam int SUM_W = VALUE_BITS + CW + 1;
	localparam int ACC_W = (SUM_W > DIFF_W + 1) ? SUM_W : DIFF_W + 1;

	state_t state_q, state_d;

	logic [CW-1:0]         cnt_q;
	logic                  ovf_q;
	logic [CW-1:0]         i_q;
	logic [CW-1:0]         j_q;
	logic [VALUE_BITS-1:0] pivot_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [DIFF_W-1:0]     diff_q;
	logic [STATUS_W-1:0]   status_q;

	logic                  in_acc;
	logic                  room;
	logic [CW-1:0]         cnt_nxt;
	logic                  last_pivot;
	logic [AW-1:0]         rd_addr;
	logic [VALUE_BITS-1:0] rd_data;
	logic [VALUE_BITS-1:0] wr_data;
	logic [CW-1:0]         rank;
	logic [CW-1:0]         half;
	logic signed [ACC_W-1:0] pv_ext;
	logic signed [ACC_W-1:0] acc_nxt;
	logic [DIFF_W-1:0]     diff_sat;
	scan_ctl_t             scan_ctl;

	assign in_acc     = s_axis_tvalid && s_axis_tready;
	assign room       = cnt_q < CW'(MAX_ITEMS);
	assign cnt_nxt    = room ? cnt_q + CW'(1) : cnt_q;
	assign last_pivot = (i_q + CW'(1)) == cnt_q;
	assign wr_data    = s_axis_tdata[VALUE_BITS-1:0];
	assign half       = cnt_q >> 1;
	assign pv_ext     = $signed(ACC_W'(pivot_q));
	assign acc_nxt    = (rank < half) ? acc_q - pv_ext : acc_q + pv_ext;
	assign diff_sat   = (acc_nxt > $signed(ACC_W'(DIFF_MAX))) ? DIFF_MAX
	                                                          : acc_nxt[DIFF_W-1:0];

	mss_mem #(
		.DEPTH(MAX_ITEMS),
		.WIDTH(VALUE_BITS)
	) u_mem (
		.clk    (clk),
		.wr_en  (in_acc && room),
		.wr_addr(cnt_q[AW-1:0]),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	mss_rank #(
		.AW   (AW),
		.CW   (CW),
		.WIDTH(VALUE_BITS)
	) u_rank (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (scan_ctl),
		.idx      (j_q[AW-1:0]),
		.data     (rd_data),
		.pivot    (pivot_q),
		.pivot_idx(i_q[AW-1:0]),
		.rank     (rank)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (in_acc && s_axis_tlast) begin
					state_d = (cnt_nxt < CW'(2)) ? ST_OUT : ST_FETCH;
				end
			end
			ST_FETCH: state_d = ST_PIVOT;
			ST_PIVOT: state_d = ST_SCAN;
			ST_SCAN: begin
				if (j_q == cnt_q) begin
					state_d = ST_ACC;
				end
			end
			ST_ACC: state_d = last_pivot ? ST_OUT : ST_FETCH;
			ST_OUT: begin
				if (m_axis_tready) begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		s_axis_tready  = 1'b0;
		m_axis_tvalid  = 1'b0;
		rd_addr        = '0;
		scan_ctl.start = 1'b0;
		scan_ctl.issue = 1'b0;
		unique case (state_q)
			ST_LOAD:  s_axis_tready = 1'b1;
			ST_FETCH: rd_addr = i_q[AW-1:0];
			ST_PIVOT: scan_ctl.start = 1'b1;
			ST_SCAN: begin
				rd_addr        = j_q[AW-1:0];
				scan_ctl.issue = j_q != cnt_q;
			end
			ST_ACC:   rd_addr = '0;
			ST_OUT:   m_axis_tvalid = 1'b1;
			default:  rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						cnt_q <= cnt_nxt;
						ovf_q <= ovf_q || !room;
						i_q   <= '0;
					end
				end
				ST_PIVOT: j_q <= '0;
				ST_SCAN: begin
					if (j_q != cnt_q) begin
						j_q <= j_q + CW'(1);
					end
				end
				ST_ACC: i_q <= i_q + CW'(1);
				ST_OUT: begin
					if (m_axis_tready) begin
						cnt_q <= '0;
						ovf_q <= 1'b0;
					end
				end
				default: j_q <= j_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && in_acc && s_axis_tlast) begin
			acc_q <= '0;
			if (cnt_nxt < CW'(2)) begin
				diff_q   <= '0;
				status_q <= STATUS_SHORT;
			end else begin
				status_q <= (ovf_q || !room) ? STATUS_OVERFLOW : STATUS_OK;
			end
		end
		if (state_q == ST_PIVOT) begin
			pivot_q <= rd_data;
		end
		if (state_q == ST_ACC) begin
			acc_q <= acc_nxt;
			if (last_pivot) begin
				diff_q <= diff_sat;
			end
		end
	end

	assign m_axis_tdata = OUT_DATA_W'(diff_q);
	assign m_axis_tuser = status_q;

endmodule

`default_nettype wire

// ===== rtl/core/mss_mem.sv =====
`default_nettype none

module mss_mem
	import mss_pkg::*;
#(
	parameter int DEPTH = DEF_MAX_ITEMS,
	parameter int WIDTH = DEF_VALUE_BITS,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

// ===== rtl/core/mss_rank.sv =====
`default_nettype none

module mss_rank
	import mss_pkg::*;
#(
	parameter int AW    = 8,
	parameter int CW    = 9,
	parameter int WIDTH = DEF_VALUE_BITS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire scan_ctl_t        ctl,
	input  wire logic [AW-1:0]    idx,
	input  wire logic [WIDTH-1:0] data,
	input  wire logic [WIDTH-1:0] pivot,
	input  wire logic [AW-1:0]    pivot_idx,
	output logic      [CW-1:0]    rank
);

	logic          valid_s1;
	logic [AW-1:0] idx_s1;
	logic [CW-1:0] rank_q;
	logic          less;

	// Ties are broken by position so that every element gets a distinct rank.
	assign less = (data < pivot) || ((data == pivot) && (idx_s1 < pivot_idx));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			rank_q   <= '0;
		end else begin
			valid_s1 <= ctl.issue;
			if (ctl.start) begin
				rank_q <= '0;
			end else if (valid_s1 && less) begin
				rank_q <= rank_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx;
	end

	assign rank = rank_q;

endmodule

`default_nettype wire

// ===== rtl/core/mss_checker.sv =====
`default_nettype none

module mss_checker
	import mss_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_axis_tvalid,
	input wire logic                  s_axis_tready,
	input wire logic                  s_axis_tlast,
	input wire logic                  m_axis_tvalid,
	input wire logic                  m_axis_tready,
	input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
	input wire logic [STATUS_W-1:0]   m_axis_tuser
);

	// The block takes no new word while a result waits.
	a_no_load_while_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input ready while a result is pending");

	// A word without tlast never produces a result.
	a_no_result_mid_set: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && !s_axis_tlast) |=> !m_axis_tvalid)
		else $error("result after a word that did not end the set");

	// A short set reports a zero difference.
	a_short_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == STATUS_SHORT) |-> (m_axis_tdata == '0))
		else $error("short set with nonzero difference");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser == STATUS_OK || m_axis_tuser == STATUS_SHORT ||
		                   m_axis_tuser == STATUS_OVERFLOW))
		else $error("undefined status code");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled result changed");

endmodule

bind median_split_sum_difference mss_checker u_mss_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tlast (s_axis_tlast),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser)
);

`default_nettype wire

// ===== test/median_split_sum_difference_test.sv =====
`timescale 1ns / 100ps

module median_split_sum_difference_test;
	import mss_pkg::*;

	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int SET_ITEMS = 1350;
	localparam logic [DEF_VALUE_BITS-1:0] VALUE_MAX = '1;

	typedef struct {
		logic [DIFF_W-1:0] difference;
		logic [STATUS_W-1:0] status;
	} split_result_t;

	class split_scoreboard;
		logic [DEF_VALUE_BITS-1:0] set_values[$];
		bit values_dropped;
		split_result_t pending_splits[$];
		int errors;

		function void note_word(logic [DEF_VALUE_BITS-1:0] value, logic last_item);
			longint unsigned ranked[DEF_MAX_ITEMS];
			longint unsigned low_sum, high_sum, gap, v;
			int n, k, j;
			split_result_t r;
			if (set_values.size() < DEF_MAX_ITEMS)
				set_values.push_back(value);
			else
				values_dropped = 1'b1;
			if (!last_item)
				return;
			n = set_values.size();
			if (n < 2) begin
				r.difference = '0;
				r.status = STATUS_SHORT;
			end else begin
				for (int i = 0; i < n; i++) begin
					v = set_values[i];
					j = i;
					while (j > 0 && ranked[j - 1] > v) begin
						ranked[j] = ranked[j - 1];
						j--;
					end
					ranked[j] = v;
				end
				k = n / 2;
				low_sum = 0;
				high_sum = 0;
				for (int i = 0; i < n; i++) begin
					if (i < k)
						low_sum += ranked[i];
					else
						high_sum += ranked[i];
				end
				gap = high_sum - low_sum;
				if (gap > DIFF_MAX)
					gap = DIFF_MAX;
				r.difference = gap[DIFF_W-1:0];
				r.status = values_dropped ? STATUS_OVERFLOW : STATUS_OK;
			end
			pending_splits.push_back(r);
			set_values.delete();
			values_dropped = 1'b0;
		endfunction

		function void check_result(logic [OUT_DATA_W-1:0] data, logic [STATUS_W-1:0] status);
			split_result_t r;
			if (pending_splits.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("Unexpected result word: difference %0d status %0d",
						data[DIFF_W-1:0], status);
				return;
			end
			r = pending_splits.pop_front();
			if (data !== {1'b0, r.difference} || status !== r.status) begin
				errors++;
				if (errors <= 10)
					$display("Mismatch: difference expected %0d got %0d, status expected %0d got %0d",
						r.difference, data, r.status, status);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [STATUS_W-1:0] m_axis_tuser;

	split_scoreboard board;
	int burst_left = 0;
	int words_sent = 0;
	int cycle_count = 0;
	int stall_phase = 0;
	logic [15:0] stall_pat = '0;

	median_split_sum_difference uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Inputs are noted before outputs are checked, so a result in the cycle right after
	// the last word always finds its expectation.
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			board.note_word(s_axis_tdata[DEF_VALUE_BITS-1:0], s_axis_tlast);
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_result(m_axis_tdata, m_axis_tuser);
		if (stall_phase == 0) begin
			stall_phase = $urandom_range(40, 160);
			stall_pat = ($urandom_range(0, 2) == 0) ? 16'h0000 : 16'($urandom) & 16'h7fff;
		end else begin
			stall_phase--;
		end
		stall_pat = {stall_pat[0], stall_pat[15:1]};
		if (arst_n)
			m_axis_tready <= !stall_pat[0];
	end

	task automatic send_word(input logic [DEF_VALUE_BITS-1:0] value, input logic last_item);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, value};
		s_axis_tlast <= last_item;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		burst_left--;
		words_sent++;
	endtask

	task automatic send_set(input int n, input int mode);
		logic [DEF_VALUE_BITS-1:0] value;
		for (int i = 0; i < n; i++) begin
			case (mode)
				0: value = DEF_VALUE_BITS'($urandom);
				1: value = DEF_VALUE_BITS'($urandom_range(0, 7));
				2: value = $urandom_range(0, 1) ? VALUE_MAX : '0;
				default: value = (i % 2) ? VALUE_MAX : '0;
			endcase
			send_word(value, i == n - 1);
		end
	endtask

	task automatic pause_until_drained();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (board.pending_splits.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		bit full_set_done, overflow_set_done;
		int n;
		board = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(31'd5, 1'b1);
		send_word('0, 1'b0);
		send_word(VALUE_MAX, 1'b1);
		send_word(VALUE_MAX, 1'b0);
		send_word('0, 1'b1);
		send_word(VALUE_MAX, 1'b0);
		send_word(VALUE_MAX, 1'b0);
		send_word(VALUE_MAX, 1'b1);
		send_word('0, 1'b0);
		send_word('0, 1'b1);
		send_word(31'd7, 1'b0);
		send_word(31'd7, 1'b0);
		send_word(31'd3, 1'b0);
		send_word(31'd7, 1'b0);
		send_word(31'd3, 1'b1);
		send_word(VALUE_MAX, 1'b0);
		send_word(VALUE_MAX, 1'b0);
		send_word('0, 1'b0);
		send_word('0, 1'b0);
		send_word(31'd1, 1'b0);
		send_word(VALUE_MAX, 1'b1);
		send_word(31'd1, 1'b1);
		pause_until_drained();

		full_set_done = 1'b0;
		overflow_set_done = 1'b0;
		while (words_sent < SET_ITEMS) begin
			if (!full_set_done && words_sent > 300) begin
				send_set(DEF_MAX_ITEMS, 3);
				full_set_done = 1'b1;
			end else if (!overflow_set_done && words_sent > 800) begin
				send_set($urandom_range(DEF_MAX_ITEMS + 1, DEF_MAX_ITEMS + 4), 0);
				overflow_set_done = 1'b1;
			end else begin
				n = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 24);
				send_set(n, $urandom_range(0, 2));
			end
			if ($urandom_range(0, 19) == 0)
				pause_until_drained();
		end
		pause_until_drained();
		repeat (50) @(posedge clk);

		if (board.errors == 0 && board.pending_splits.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
